### rtl/flpa_pkg.sv
// ----------------------------------------------------------------------------
// flpa_pkg
// Shared types and fixed field widths of the free list page allocator.
// ----------------------------------------------------------------------------
package flpa_pkg;

  localparam int PAGE_W      = 10;  // page_in, page_out, head_after
  localparam int COUNT_W     = 11;  // pages_after
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;  // page_in, zero filled to 2 bytes
  localparam int OUT_TDATA_W = 32;  // page_out, head_after, pages_after, zero fill

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PAGE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // latch the accepted item
    logic grow_step;  // write one link of a new batch
    logic commit;     // update head/count and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_grow;  // current item is an alloc that grows the store
    logic grow_last;  // this grow step writes the final link
  } dp_stat_t;

endpackage

### rtl/flpa_ctrl.sv
// ----------------------------------------------------------------------------
// flpa_ctrl
// Sequencer: accept, decide, run the batch link writes, hand off the result.
// ----------------------------------------------------------------------------
module flpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output flpa_pkg::dp_cmd_t  cmd,
  input  flpa_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_GROW = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_grow) begin
          state_nxt = S_GROW;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_GROW: begin
        cmd.grow_step = 1'b1;
        if (stat.grow_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/flpa_datapath.sv
// ----------------------------------------------------------------------------
// flpa_datapath
// Head pointer, page count, link memory, batch counter and result register.
// ----------------------------------------------------------------------------
module flpa_datapath #(
  parameter int MAX_PAGES  = 1024,
  parameter int GROW_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  flpa_pkg::dp_cmd_t               cmd,
  output flpa_pkg::dp_stat_t              stat,
  input  logic                            in_opcode,
  input  logic [flpa_pkg::PAGE_W-1:0]     in_page,
  output logic [flpa_pkg::PAGE_W-1:0]     out_page,
  output logic [flpa_pkg::STATUS_W-1:0]   out_status,
  output logic [flpa_pkg::PAGE_W-1:0]     out_head,
  output logic [flpa_pkg::COUNT_W-1:0]    out_pages
);

  localparam int PageW  = flpa_pkg::PAGE_W;
  localparam int CountW = flpa_pkg::COUNT_W;
  localparam int PW     = $clog2(MAX_PAGES);
  localparam int CW     = $clog2(MAX_PAGES + 1);
  localparam int GW     = $clog2(GROW_COUNT);
  localparam int SW     = CW + 9;              // room for count + batch size
  localparam int XW     = (CW > PageW) ? CW : PageW;

  typedef enum logic [2:0] {
    K_POP, K_GROW, K_FULL, K_PUSH, K_BAD
  } kind_t;

  logic [PW-1:0]    link_mem [MAX_PAGES];
  logic [PW-1:0]    rd_link_r;
  logic [PW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic             op_r;
  logic [PageW-1:0] pg_r;
  logic [GW-1:0]    cnt_r;
  kind_t            kind;

  logic             wr_en;
  logic [PW-1:0]    wr_addr;
  logic [PW-1:0]    wr_data;
  logic [SW-1:0]    grow_addr;

  logic [PageW-1:0]    res_page_r,   res_page_nxt;
  flpa_pkg::status_t   res_status_r, res_status_nxt;
  logic [PageW-1:0]    res_head_r;
  logic [CountW-1:0]   res_pages_r;

  // classify the latched item
  always_comb begin
    if (op_r == flpa_pkg::OP_ALLOC) begin
      if (head_r != '0) begin
        kind = K_POP;
      end else if (SW'(total_r) + SW'(GROW_COUNT) > SW'(MAX_PAGES)) begin
        kind = K_FULL;
      end else begin
        kind = K_GROW;
      end
    end else begin
      if (pg_r != '0 && XW'(pg_r) < XW'(total_r)) begin
        kind = K_PUSH;
      end else begin
        kind = K_BAD;
      end
    end
  end

  assign stat.need_grow = (kind == K_GROW);
  assign stat.grow_last = (cnt_r == GW'(GROW_COUNT - 1));

  // batch link: page base+cnt points at base+cnt+1, last one ends the list
  assign grow_addr = SW'(total_r) + SW'(cnt_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = PW'(grow_addr);
    wr_data = stat.grow_last ? '0 : PW'(grow_addr + SW'(1));
    if (cmd.grow_step) begin
      wr_en = 1'b1;
    end else if (cmd.commit && kind == K_PUSH) begin
      wr_en   = 1'b1;
      wr_addr = PW'(pg_r);
      wr_data = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  // link of the current head, registered, valid in the cycle after the head settles
  always_ff @(posedge clk) begin
    rd_link_r <= link_mem[head_r];
  end

  always_comb begin
    head_nxt       = head_r;
    total_nxt      = total_r;
    res_page_nxt   = '0;
    res_status_nxt = flpa_pkg::ST_OK;
    unique case (kind)
      K_POP: begin
        res_page_nxt = PageW'(head_r);
        head_nxt     = rd_link_r;
      end
      K_GROW: begin
        res_page_nxt = PageW'(total_r);
        head_nxt     = PW'(SW'(total_r) + SW'(1));
        total_nxt    = CW'(SW'(total_r) + SW'(GROW_COUNT));
      end
      K_PUSH: begin
        head_nxt = PW'(pg_r);
      end
      K_FULL: begin
        res_status_nxt = flpa_pkg::ST_FULL;
      end
      K_BAD: begin
        res_status_nxt = flpa_pkg::ST_BAD_PAGE;
      end
      default: begin
        res_status_nxt = flpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      total_r <= CW'(1);
    end else if (cmd.commit) begin
      head_r  <= head_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      pg_r  <= in_page;
      cnt_r <= GW'(1);
    end else if (cmd.grow_step) begin
      cnt_r <= cnt_r + GW'(1);
    end
    if (cmd.commit) begin
      res_page_r   <= res_page_nxt;
      res_status_r <= res_status_nxt;
      res_head_r   <= PageW'(head_nxt);
      res_pages_r  <= CountW'(total_nxt);
    end
  end

  assign out_page   = res_page_r;
  assign out_status = res_status_r;
  assign out_head   = res_head_r;
  assign out_pages  = res_pages_r;

endmodule

### rtl/free_list_page_allocator.sv
// Sequence: accept, then classify and commit the result for pop, push and
//   errors; an alloc that grows the store first runs its batch link writes.
// One item in flight; the result is committed once the output register is
//   free, and the GROW_COUNT - 1 batch link writes use the single write port.
// Reset: rst_n synchronous, active low; empty free list, one page (header).
//   The link memory is not cleared; every entry is written before its link is used.
// ----------------------------------------------------------------------------
// free_list_page_allocator
// Page allocator over a singly linked free list kept in a link memory.
// ----------------------------------------------------------------------------
module free_list_page_allocator #(
  parameter int MAX_PAGES  = 1024,  // link memory depth, 16 .. 1024
  parameter int GROW_COUNT = 16     // pages added when the list runs dry, 2 .. 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [flpa_pkg::IN_TDATA_W-1:0]    in_tdata,   // [9:0] page_in, rest zero
  input  logic                               in_tuser,   // [0] opcode
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [flpa_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] page_out,
                                                         // [19:10] head_after,
                                                         // [30:20] pages_after
  output logic [flpa_pkg::STATUS_W-1:0]      out_tuser   // [1:0] status
);

  localparam int PageW  = flpa_pkg::PAGE_W;
  localparam int CountW = flpa_pkg::COUNT_W;
  localparam int PadW   = flpa_pkg::OUT_TDATA_W - 2 * PageW - CountW;

  flpa_pkg::dp_cmd_t  cmd;
  flpa_pkg::dp_stat_t stat;

  logic [PageW-1:0]  res_page;
  logic [PageW-1:0]  res_head;
  logic [CountW-1:0] res_pages;

  // Controller: one item in flight. It accepts as soon as it is idle, even
  // with the previous result still held in the output register; the result
  // is only loaded once that register is free.
  flpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Datapath: head/count registers, link memory with registered read of the
  // current head's link, batch counter for growth, result register.
  flpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .GROW_COUNT (GROW_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_tuser),
    .in_page    (in_tdata[PageW-1:0]),
    .out_page   (res_page),
    .out_status (out_tuser),
    .out_head   (res_head),
    .out_pages  (res_pages)
  );

  assign out_tdata = {{PadW{1'b0}}, res_pages, res_head, res_page};

endmodule
